@@ hdl/dstf_pkg.sv @@
// Shared types, constants and the fraction weight table for the decimal string converter.
package dstf_pkg;

  localparam int FRAC_DIGITS = 10;
  localparam int MAX_TABLE_DIGITS = 19;

  localparam logic [31:0] INT_MAX_Q = 32'h7FFF_FFFF;
  localparam logic [31:0] FRAC_MAX_Q = 32'hFFFF_FFFF;
  localparam logic [4:0] POS_MAX = 5'd31;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_SIGN = 3'd1,
    PH_INT = 3'd2,
    PH_DOT = 3'd3,
    PH_FRAC = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  // Finished string, before sign is applied.
  typedef struct packed {
    logic [31:0] int_part;
    logic [31:0] frac_part;
    logic        negative;
    logic        format_error;
    logic        overflow;
  } parse_result_t;

  // round(2^32 / 10^k), halves up; zero past the table.
  function automatic logic [31:0] frac_weight(input logic [4:0] k);
    logic [31:0] w;
    case (k)
      5'd1: w = 32'd429496730;
      5'd2: w = 32'd42949673;
      5'd3: w = 32'd4294967;
      5'd4: w = 32'd429497;
      5'd5: w = 32'd42950;
      5'd6: w = 32'd4295;
      5'd7: w = 32'd429;
      5'd8: w = 32'd43;
      5'd9: w = 32'd4;
      default: w = 32'd0;
    endcase
    return w;
  endfunction

endpackage

@@ hdl/dstf_parser.sv @@
// Character parser: phase machine with integer and fraction accumulators.
module dstf_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              char_code,
  output dstf_pkg::parse_result_t result
);

  dstf_pkg::phase_t phase, phase_next;
  logic        negative, negative_next;
  logic [31:0] integer_acc, integer_acc_next;
  logic [31:0] fraction_acc, fraction_acc_next;
  logic [4:0]  digit_position, digit_position_next;
  logic        error_seen, error_seen_next;
  logic        overflow_seen, overflow_seen_next;

  logic        is_digit;
  logic [3:0]  digit;
  logic [35:0] int_sum;
  logic        int_sat;
  logic [31:0] int_digit_acc;
  logic [4:0]  pos_inc;
  logic        frac_en;
  logic [35:0] frac_term;
  logic [36:0] frac_sum;
  logic [31:0] frac_digit_acc;

  assign is_digit = (char_code >= dstf_pkg::CH_ZERO) && (char_code <= dstf_pkg::CH_NINE);
  assign digit = is_digit ? 4'(char_code - dstf_pkg::CH_ZERO) : 4'd0;

  // acc * 10 + d as acc * 8 + acc * 2 + d
  assign int_sum = {1'b0, integer_acc, 3'b000} + {3'b000, integer_acc, 1'b0}
                   + {32'd0, digit};
  assign int_sat = int_sum > {4'd0, dstf_pkg::INT_MAX_Q};
  assign int_digit_acc = int_sat ? dstf_pkg::INT_MAX_Q : int_sum[31:0];

  assign pos_inc = (digit_position < dstf_pkg::POS_MAX) ? digit_position + 5'd1
                                                        : digit_position;
  assign frac_en = (32'(pos_inc) <= 32'(dstf_pkg::FRAC_DIGITS))
                   && (32'(pos_inc) <= 32'(dstf_pkg::MAX_TABLE_DIGITS));
  assign frac_term = dstf_pkg::frac_weight(pos_inc) * {32'd0, digit};
  assign frac_sum = {5'd0, fraction_acc} + {1'b0, frac_term};
  assign frac_digit_acc = !frac_en ? fraction_acc
                        : (frac_sum > {5'd0, dstf_pkg::FRAC_MAX_Q}) ? dstf_pkg::FRAC_MAX_Q
                        : frac_sum[31:0];

  always_comb begin
    phase_next = phase;
    negative_next = negative;
    integer_acc_next = integer_acc;
    fraction_acc_next = fraction_acc;
    digit_position_next = digit_position;
    error_seen_next = error_seen;
    overflow_seen_next = overflow_seen;
    case (phase)
      dstf_pkg::PH_LEAD: begin
        if (char_code == dstf_pkg::CH_SPACE) begin
          phase_next = dstf_pkg::PH_LEAD;
        end else if (char_code == dstf_pkg::CH_PLUS || char_code == dstf_pkg::CH_MINUS) begin
          negative_next = (char_code == dstf_pkg::CH_MINUS);
          phase_next = dstf_pkg::PH_SIGN;
        end else if (is_digit) begin
          integer_acc_next = int_digit_acc;
          overflow_seen_next = overflow_seen | int_sat;
          phase_next = dstf_pkg::PH_INT;
        end else if (char_code == dstf_pkg::CH_DOT) begin
          phase_next = dstf_pkg::PH_DOT;
        end else begin
          phase_next = dstf_pkg::PH_DONE;
        end
      end
      dstf_pkg::PH_SIGN: begin
        if (is_digit) begin
          integer_acc_next = int_digit_acc;
          overflow_seen_next = overflow_seen | int_sat;
          phase_next = dstf_pkg::PH_INT;
        end else if (char_code == dstf_pkg::CH_DOT) begin
          error_seen_next = 1'b1;
          phase_next = dstf_pkg::PH_DOT;
        end else begin
          error_seen_next = 1'b1;
          phase_next = dstf_pkg::PH_DONE;
        end
      end
      dstf_pkg::PH_INT: begin
        if (is_digit) begin
          integer_acc_next = int_digit_acc;
          overflow_seen_next = overflow_seen | int_sat;
        end else if (char_code == dstf_pkg::CH_DOT) begin
          phase_next = dstf_pkg::PH_DOT;
        end else begin
          phase_next = dstf_pkg::PH_DONE;
        end
      end
      dstf_pkg::PH_DOT, dstf_pkg::PH_FRAC: begin
        if (is_digit) begin
          digit_position_next = pos_inc;
          fraction_acc_next = frac_digit_acc;
          phase_next = dstf_pkg::PH_FRAC;
        end else begin
          error_seen_next = 1'b1;
          phase_next = dstf_pkg::PH_DONE;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  // result of the string as it stands, used when the terminator arrives
  always_comb begin
    result.int_part = integer_acc;
    result.frac_part = fraction_acc;
    result.negative = negative;
    result.format_error = error_seen || (phase == dstf_pkg::PH_SIGN)
                          || (phase == dstf_pkg::PH_DOT);
    result.overflow = overflow_seen;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && char_code == dstf_pkg::CH_NUL)) begin
      phase <= dstf_pkg::PH_LEAD;
      negative <= 1'b0;
      integer_acc <= '0;
      fraction_acc <= '0;
      digit_position <= '0;
      error_seen <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      negative <= negative_next;
      integer_acc <= integer_acc_next;
      fraction_acc <= fraction_acc_next;
      digit_position <= digit_position_next;
      error_seen <= error_seen_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

@@ hdl/dstf_result.sv @@
// Result register: applies the sign and holds the result until it is taken.
module dstf_result (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  dstf_pkg::parse_result_t result,
  output logic                    valid,
  input  logic                    stall,
  output logic signed [63:0]      value,
  output logic                    format_error,
  output logic                    overflow
);

  logic [63:0] magnitude;

  assign magnitude = {result.int_part, result.frac_part};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value <= result.negative ? -$signed(magnitude) : $signed(magnitude);
      format_error <= result.format_error;
      overflow <= result.overflow;
    end
  end

endmodule

@@ hdl/decimal_string_to_fixed.sv @@
// Top level: ASCII decimal string to signed Q31.32 converter.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------
//   input    | in_valid / in_stall | char_code[7:0]
//   output   | out_valid/out_stall | value[63:0], format_error, overflow
//
// One character per cycle is taken while in_stall is low. A request is registered in the
// input register, then parsed from there; a zero byte in the input register loads the
// result register once that register is free, and its result is taken from there.
// Only a zero byte can back up: it waits in the input register while the
// result register is full and stalled, and other characters keep flowing.
// rst is synchronous and returns the parser to its leading-space phase.
module decimal_string_to_fixed (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] value,
  output logic               format_error,
  output logic               overflow
);

  logic       char_valid;
  logic [7:0] char_q;
  logic       out_free;
  logic       consume;
  logic       load_out;
  dstf_pkg::parse_result_t result;

  assign out_free = !out_valid || !out_stall;
  assign consume = char_valid && ((char_q != dstf_pkg::CH_NUL) || out_free);
  assign load_out = consume && (char_q == dstf_pkg::CH_NUL);
  assign in_stall = char_valid && !consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      char_valid <= 1'b1;
    end else if (consume) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_q <= char_code;
    end
  end

  dstf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (consume),
    .char_code (char_q),
    .result    (result)
  );

  dstf_result u_result (
    .clk          (clk),
    .rst          (rst),
    .load         (load_out),
    .result       (result),
    .valid        (out_valid),
    .stall        (out_stall),
    .value        (value),
    .format_error (format_error),
    .overflow     (overflow)
  );

  // a stalled result is never overwritten by the next terminator
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !load_out)
    else $error("result overwritten while stalled");

  // only a terminator is ever held back at the input
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (char_valid && char_q == dstf_pkg::CH_NUL))
    else $error("non-terminator stalled");

  // a loaded result shows up as valid in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("result lost after load");

endmodule

@@ bench/tb_decimal_string_to_fixed.sv @@
// Self-checking bench for the ASCII decimal string to Q31.32 converter.
module tb_decimal_string_to_fixed;

  localparam int IDLE_PCT       = 34;
  localparam int RANDOM_CHARS   = 800;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int END_CYCLES     = 10;

  typedef struct packed {
    logic signed [63:0] value;
    logic               format_error;
    logic               overflow;
  } fixed_result_t;

  typedef struct {
    string         text;
    bit            typed;
    fixed_result_t res;
  } directed_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         char_code;
  logic               out_valid;
  logic               out_stall;
  logic signed [63:0] value;
  logic               format_error;
  logic               overflow;

  // parser copy used for prediction
  dstf_pkg::phase_t ps_phase;
  logic        ps_negative;
  logic [31:0] ps_int;
  logic [31:0] ps_frac;
  logic [4:0]  ps_pos;
  logic        ps_err;
  logic        ps_ovf;

  fixed_result_t expected_results[$];
  directed_row_t directed_rows[$];

  // typed expectation that rides along with the zero byte of a directed row
  bit            typed_ok;
  fixed_result_t typed_res;

  bit calm;
  bit hold_go;
  bit hold_done;
  int failures;
  int chars_sent;
  int idle_cycles;

  decimal_string_to_fixed i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .format_error (format_error),
    .overflow     (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // round(2^32 / 10^k), half up: floor((floor(2^33 / 10^k) + 1) / 2)
  function automatic logic [31:0] fraction_weight(input int k);
    logic [63:0] p;
    p = 64'd1;
    repeat (k) p = p * 64'd10;
    return 32'(((64'd1 << 33) / p + 64'd1) >> 1);
  endfunction

  task automatic clear_parser();
    ps_phase    = dstf_pkg::PH_LEAD;
    ps_negative = 1'b0;
    ps_int      = '0;
    ps_frac     = '0;
    ps_pos      = '0;
    ps_err      = 1'b0;
    ps_ovf      = 1'b0;
  endtask

  task automatic add_int_digit(input logic [3:0] d);
    logic [63:0] t;
    t = 64'(ps_int) * 64'd10 + 64'(d);
    if (t > 64'(dstf_pkg::INT_MAX_Q)) begin
      ps_int = dstf_pkg::INT_MAX_Q;
      ps_ovf = 1'b1;
    end else begin
      ps_int = t[31:0];
    end
  endtask

  task automatic parse_char(input logic [7:0] c, output bit emit, output fixed_result_t r);
    logic        dig;
    logic [3:0]  d;
    logic [63:0] mag;
    logic [63:0] t;
    dig  = (c >= dstf_pkg::CH_ZERO) && (c <= dstf_pkg::CH_NINE);
    d    = c[3:0];
    emit = 1'b0;
    r    = '0;
    if (c == dstf_pkg::CH_NUL) begin
      if (ps_phase == dstf_pkg::PH_SIGN || ps_phase == dstf_pkg::PH_DOT) ps_err = 1'b1;
      mag = {ps_int, ps_frac};
      r.value        = ps_negative ? -mag : mag;
      r.format_error = ps_err;
      r.overflow     = ps_ovf;
      emit = 1'b1;
      clear_parser();
    end else begin
      case (ps_phase)
        dstf_pkg::PH_LEAD: begin
          if (c == dstf_pkg::CH_SPACE) begin
          end else if (c == dstf_pkg::CH_PLUS || c == dstf_pkg::CH_MINUS) begin
            ps_negative = (c == dstf_pkg::CH_MINUS);
            ps_phase    = dstf_pkg::PH_SIGN;
          end else if (dig) begin
            add_int_digit(d);
            ps_phase = dstf_pkg::PH_INT;
          end else if (c == dstf_pkg::CH_DOT) begin
            ps_phase = dstf_pkg::PH_DOT;
          end else begin
            ps_phase = dstf_pkg::PH_DONE;
          end
        end
        dstf_pkg::PH_SIGN: begin
          if (dig) begin
            add_int_digit(d);
            ps_phase = dstf_pkg::PH_INT;
          end else begin
            ps_err   = 1'b1;
            ps_phase = (c == dstf_pkg::CH_DOT) ? dstf_pkg::PH_DOT : dstf_pkg::PH_DONE;
          end
        end
        dstf_pkg::PH_INT: begin
          if (dig) add_int_digit(d);
          else if (c == dstf_pkg::CH_DOT) ps_phase = dstf_pkg::PH_DOT;
          else ps_phase = dstf_pkg::PH_DONE;
        end
        dstf_pkg::PH_DOT, dstf_pkg::PH_FRAC: begin
          if (dig) begin
            if (ps_pos < dstf_pkg::POS_MAX) ps_pos = ps_pos + 5'd1;
            if (ps_pos <= dstf_pkg::FRAC_DIGITS && ps_pos <= dstf_pkg::MAX_TABLE_DIGITS) begin
              t = 64'(ps_frac) + 64'(d) * 64'(fraction_weight(ps_pos));
              ps_frac = (t > 64'(dstf_pkg::FRAC_MAX_Q)) ? dstf_pkg::FRAC_MAX_Q : t[31:0];
            end
            ps_phase = dstf_pkg::PH_FRAC;
          end else begin
            ps_err   = 1'b1;
            ps_phase = dstf_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic send_char(input logic [7:0] c, input bit typed, input fixed_result_t tr);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    char_code = c;
    typed_ok  = typed;
    typed_res = tr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    typed_ok = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic add_row(input string s, input bit typed, input logic [63:0] v,
                         input bit e, input bit o);
    directed_row_t row;
    row.text  = s;
    row.typed = typed;
    row.res   = '{v, e, o};
    directed_rows.push_back(row);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall = !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin : monitor
    fixed_result_t got;
    fixed_result_t want;
    bit            emit;
    bit            moved;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        got.value        = value;
        got.format_error = format_error;
        got.overflow     = overflow;
        if (expected_results.size() == 0) begin
          $error("unexpected result: value %h format_error %b overflow %b",
                 got.value, got.format_error, got.overflow);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (got.value !== want.value) begin
            $error("value: expected %h, actual %h", want.value, got.value);
            failures++;
          end
          if (got.format_error !== want.format_error) begin
            $error("format_error: expected %b, actual %b", want.format_error,
                   got.format_error);
            failures++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow: expected %b, actual %b", want.overflow, got.overflow);
            failures++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        parse_char(char_code, emit, want);
        if (emit) begin
          if (typed_ok) want = typed_res;
          expected_results.push_back(want);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] txt[$];
    logic [7:0] b;
    int         rnd_start;
    int         n;
    int         kind;
    int         sign;
    bit         drained;
    rst       = 1'b1;
    in_valid  = 1'b0;
    char_code = '0;
    typed_ok  = 1'b0;
    typed_res = '0;
    calm      = 1'b0;
    hold_go   = 1'b0;
    hold_done = 1'b0;
    drained   = 1'b0;
    failures  = 0;
    chars_sent = 0;
    clear_parser();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_row("", 1, 64'h0, 0, 0);
    add_row("-", 1, 64'h0, 1, 0);
    add_row(".", 1, 64'h0, 1, 0);
    add_row("5.", 1, 64'h0000_0005_0000_0000, 1, 0);
    add_row("2147483647", 1, 64'h7FFF_FFFF_0000_0000, 0, 0);
    add_row("-2147483648", 1, 64'h8000_0001_0000_0000, 0, 1);
    add_row("-0", 1, 64'h0, 0, 0);
    add_row(" +3.14", 0, '0, 0, 0);
    add_row("1.5z", 0, '0, 0, 0);
    add_row("--1", 0, '0, 0, 0);
    add_row("+.5", 0, '0, 0, 0);
    add_row("0.99999999999", 0, '0, 0, 0);
    add_row("7 9", 0, '0, 0, 0);
    add_row("\3771", 0, '0, 0, 0);

    foreach (directed_rows[r]) begin
      for (int i = 0; i < directed_rows[r].text.len(); i++)
        send_char(directed_rows[r].text[i], 1'b0, '0);
      send_char(dstf_pkg::CH_NUL, directed_rows[r].typed, directed_rows[r].res);
    end

    rnd_start = chars_sent;
    n = 0;
    while (n < RANDOM_CHARS) begin
      calm = (n >= 150 && n < 300);
      if (n >= 400) hold_go = 1'b1;
      if (n >= 600 && !drained) begin
        drained = 1'b1;
        wait_for_results();
      end
      txt.delete();
      kind = $urandom_range(99);
      if (kind < 12) begin
        // noise
        repeat ($urandom_range(1, 6)) begin
          b = 8'($urandom_range(1, 255));
          txt.push_back(b);
        end
      end else begin
        repeat (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0)
          txt.push_back(dstf_pkg::CH_SPACE);
        sign = $urandom_range(2);
        if (sign == 1) txt.push_back(dstf_pkg::CH_PLUS);
        if (sign == 2) txt.push_back(dstf_pkg::CH_MINUS);
        repeat (($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4)) begin
          b = dstf_pkg::CH_ZERO + 8'($urandom_range(9));
          txt.push_back(b);
        end
        if ($urandom_range(9) < 7) begin
          txt.push_back(dstf_pkg::CH_DOT);
          repeat (($urandom_range(9) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 4)) begin
            b = dstf_pkg::CH_ZERO + 8'($urandom_range(9));
            txt.push_back(b);
          end
        end
        if (kind >= 82) begin
          // broken: one stray byte somewhere in the string
          b = 8'($urandom_range(1, 255));
          txt.insert($urandom_range(txt.size()), b);
        end
      end
      foreach (txt[i]) send_char(txt[i], 1'b0, '0);
      send_char(dstf_pkg::CH_NUL, 1'b0, '0);
      n = chars_sent - rnd_start;
    end
    calm = 1'b0;

    wait_for_results();
    repeat (END_CYCLES) @(negedge clk);
    if (failures == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
